/* src/svt_pkg.sv */
`timescale 1ns / 1ps
// Constants, types and the control program of the summed-volume table block.
package svt_pkg;

	localparam int MAX_X = 64;
	localparam int MAX_Y = 64;
	localparam int MAX_Z = 16;

	localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW = $clog2(DEPTH);

	// Width of the extent and window arithmetic; holds any extent up to 4095.
	localparam int NW = 12;

	localparam int STEPW = 5;
	localparam logic [STEPW-1:0] ENTRY_LOAD  = 5'd0;
	localparam logic [STEPW-1:0] STEP_STORE  = 5'd7;
	localparam logic [STEPW-1:0] ENTRY_QUERY = 5'd8;
	localparam logic [STEPW-1:0] STEP_FINISH = 5'd16;

	localparam logic [2:0] REG_SIZE_X   = 3'd0;
	localparam logic [2:0] REG_SIZE_Y   = 3'd1;
	localparam logic [2:0] REG_SIZE_Z   = 3'd2;
	localparam logic [2:0] REG_WINDOW_X = 3'd3;
	localparam logic [2:0] REG_WINDOW_Y = 3'd4;
	localparam logic [2:0] REG_WINDOW_Z = 3'd5;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		OP_READ,
		OP_STORE,
		OP_FINISH
	} op_t;

	// The mask selects the lower corner on each axis: bit 0 x, bit 1 y, bit 2 z.
	typedef struct packed {
		op_t              op;
		logic [2:0]       mask;
		logic             skip_2d;
		logic [STEPW-1:0] target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [STEPW-1:0] step);
		ucode_t w;
		w = '{op: OP_FINISH, mask: 3'd0, skip_2d: 1'b0, target: ENTRY_LOAD};
		case (step)
			5'd0:  w = '{OP_READ,   3'd1, 1'b0, ENTRY_LOAD};
			5'd1:  w = '{OP_READ,   3'd2, 1'b0, ENTRY_LOAD};
			5'd2:  w = '{OP_READ,   3'd3, 1'b1, STEP_STORE};
			5'd3:  w = '{OP_READ,   3'd4, 1'b0, ENTRY_LOAD};
			5'd4:  w = '{OP_READ,   3'd5, 1'b0, ENTRY_LOAD};
			5'd5:  w = '{OP_READ,   3'd6, 1'b0, ENTRY_LOAD};
			5'd6:  w = '{OP_READ,   3'd7, 1'b0, ENTRY_LOAD};
			5'd7:  w = '{OP_STORE,  3'd0, 1'b0, ENTRY_LOAD};
			5'd8:  w = '{OP_READ,   3'd0, 1'b0, ENTRY_LOAD};
			5'd9:  w = '{OP_READ,   3'd1, 1'b0, ENTRY_LOAD};
			5'd10: w = '{OP_READ,   3'd2, 1'b0, ENTRY_LOAD};
			5'd11: w = '{OP_READ,   3'd3, 1'b1, STEP_FINISH};
			5'd12: w = '{OP_READ,   3'd4, 1'b0, ENTRY_LOAD};
			5'd13: w = '{OP_READ,   3'd5, 1'b0, ENTRY_LOAD};
			5'd14: w = '{OP_READ,   3'd6, 1'b0, ENTRY_LOAD};
			5'd15: w = '{OP_READ,   3'd7, 1'b0, ENTRY_LOAD};
			5'd16: w = '{OP_FINISH, 3'd0, 1'b0, ENTRY_LOAD};
			default: w = '{OP_FINISH, 3'd0, 1'b0, ENTRY_LOAD};
		endcase
		return w;
	endfunction

endpackage

/* src/summed_volume_table_window_sum.sv */
`timescale 1ns / 1ps
// Summed-volume table: builds the 3D integral of a loaded image and returns box-window sums.
// One item is worked on at a time; each read step of the control program reads at most one
// table entry from the single-port table memory. A load reads its neighbours, then stores;
// a query reads the window corners, then finishes; either waits at its end for the output.
// A new item is accepted in the cycle after the result is placed in the output register.
// Reset clears the control state and the load position and sets the registers to their
// defaults; the table contents are undefined until loaded and are never cleared.
module summed_volume_table_window_sum
	import svt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pixel[15:0], end_x[22:16], end_y[29:23], end_z[34:30], zero
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value[31:0]
	output logic        m_tuser,   // result_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] size_x_q, size_y_q, window_x_q, window_y_q;
	logic [4:0] size_z_q, window_z_q;
	logic [XW-1:0] load_x_q;
	logic [YW-1:0] load_y_q;
	logic [ZW-1:0] load_z_q;

	logic             busy_q;
	logic [STEPW-1:0] step_q;
	logic             rd_en_s1;
	logic             rd_sub_s1;
	logic             m_tvalid_q;

	logic             kind_q;
	logic [XW-1:0]    hi_x_q, lo_x_q;
	logic [YW-1:0]    hi_y_q, lo_y_q;
	logic [ZW-1:0]    hi_z_q, lo_z_q;
	logic [2:0]       flags_q;
	logic [31:0]      acc_q;
	logic [31:0]      rdata_q;
	logic [31:0]      m_tdata_q;
	logic             m_tuser_q;

	logic [31:0] mem [DEPTH];

	function automatic logic [NW-1:0] eff_size(input logic [6:0] s, input logic [NW-1:0] maxv);
		logic [NW-1:0] se;
		se = NW'(s);
		if (se == '0) begin
			return NW'(1);
		end
		return (se > maxv) ? maxv : se;
	endfunction

	function automatic logic [NW-1:0] axis_begin(input logic [NW-1:0] e, input logic [NW-1:0] s,
			input logic [NW-1:0] w);
		if (w > e) begin
			return '0;
		end
		if (e >= s) begin
			return (w > s) ? '0 : s - w;
		end
		return e + NW'(1) - w;
	endfunction

	logic [NW-1:0] sx, sy, sz;
	logic [NW-1:0] ex, ey, ez, cx, cy, cz, bx, by, bz;
	logic          cfg_we;
	logic          accept;
	ucode_t        cw;
	logic          term_en, rd_en, rd_sub, out_free, advance, mem_we;
	logic [31:0]   acc_next;
	logic [STEPW-1:0] step_next;
	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	logic [ZW-1:0] az;
	logic [AW-1:0] addr;

	assign sx = eff_size(size_x_q, NW'(MAX_X));
	assign sy = eff_size(size_y_q, NW'(MAX_Y));
	assign sz = eff_size({2'b00, size_z_q}, NW'(MAX_Z));

	assign ex = NW'(s_tdata[22:16]);
	assign ey = NW'(s_tdata[29:23]);
	assign ez = NW'(s_tdata[34:30]);
	assign cx = (ex >= sx) ? sx - NW'(1) : ex;
	assign cy = (ey >= sy) ? sy - NW'(1) : ey;
	assign cz = (ez >= sz) ? sz - NW'(1) : ez;
	assign bx = axis_begin(ex, sx, NW'(window_x_q));
	assign by = axis_begin(ey, sy, NW'(window_y_q));
	assign bz = (sz == NW'(1)) ? '0 : axis_begin(ez, sz, NW'(window_z_q));

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	assign cw       = ucode_rom(step_q);
	assign term_en  = (cw.mask & ~flags_q) == 3'b000;
	assign rd_en    = busy_q && (cw.op == OP_READ) && term_en;
	assign rd_sub   = kind_q ? (^cw.mask) : !(^cw.mask);
	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = busy_q && ((cw.op == OP_READ) || out_free);
	assign mem_we   = busy_q && (cw.op == OP_STORE) && out_free;
	assign acc_next = rd_en_s1 ? (rd_sub_s1 ? acc_q - rdata_q : acc_q + rdata_q) : acc_q;
	assign step_next = (cw.skip_2d && !flags_q[2]) ? cw.target : step_q + STEPW'(1);

	assign ax   = cw.mask[0] ? lo_x_q : hi_x_q;
	assign ay   = cw.mask[1] ? lo_y_q : hi_y_q;
	assign az   = cw.mask[2] ? lo_z_q : hi_z_q;
	assign addr = AW'(az) * AW'(MAX_X * MAX_Y) + AW'(ay) * AW'(MAX_X) + AW'(ax);

	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			REG_SIZE_X:   prdata = {25'd0, size_x_q};
			REG_SIZE_Y:   prdata = {25'd0, size_y_q};
			REG_SIZE_Z:   prdata = {27'd0, size_z_q};
			REG_WINDOW_X: prdata = {25'd0, window_x_q};
			REG_WINDOW_Y: prdata = {25'd0, window_y_q};
			REG_WINDOW_Z: prdata = {27'd0, window_z_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= 7'd64;
			size_y_q   <= 7'd64;
			size_z_q   <= 5'd1;
			window_x_q <= 7'd1;
			window_y_q <= 7'd1;
			window_z_q <= 5'd1;
			load_x_q   <= '0;
			load_y_q   <= '0;
			load_z_q   <= '0;
			busy_q     <= 1'b0;
			step_q     <= ENTRY_LOAD;
			rd_en_s1   <= 1'b0;
			rd_sub_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance && (cw.op != OP_READ)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (paddr[4:2])
					REG_SIZE_X: begin
						size_x_q <= pwdata[6:0];
						load_x_q <= '0;
						load_y_q <= '0;
						load_z_q <= '0;
					end
					REG_SIZE_Y: begin
						size_y_q <= pwdata[6:0];
						load_x_q <= '0;
						load_y_q <= '0;
						load_z_q <= '0;
					end
					REG_SIZE_Z: begin
						size_z_q <= pwdata[4:0];
						load_x_q <= '0;
						load_y_q <= '0;
						load_z_q <= '0;
					end
					REG_WINDOW_X: window_x_q <= pwdata[6:0];
					REG_WINDOW_Y: window_y_q <= pwdata[6:0];
					REG_WINDOW_Z: window_z_q <= pwdata[4:0];
					default: ;
				endcase
			end
			if (accept) begin
				busy_q   <= 1'b1;
				step_q   <= s_tuser ? ENTRY_QUERY : ENTRY_LOAD;
				rd_en_s1 <= 1'b0;
			end else if (advance) begin
				rd_en_s1  <= rd_en;
				rd_sub_s1 <= rd_sub;
				step_q    <= step_next;
				if (cw.op != OP_READ) begin
					busy_q <= 1'b0;
				end
				if (cw.op == OP_STORE) begin
					if (NW'(load_x_q) + NW'(1) < sx) begin
						load_x_q <= load_x_q + XW'(1);
					end else begin
						load_x_q <= '0;
						if (NW'(load_y_q) + NW'(1) < sy) begin
							load_y_q <= load_y_q + YW'(1);
						end else begin
							load_y_q <= '0;
							load_z_q <= (NW'(load_z_q) + NW'(1) < sz) ?
								load_z_q + ZW'(1) : '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			if (s_tuser == KIND_QUERY) begin
				acc_q   <= '0;
				hi_x_q  <= XW'(cx);
				hi_y_q  <= YW'(cy);
				hi_z_q  <= ZW'(cz);
				lo_x_q  <= XW'(bx - NW'(1));
				lo_y_q  <= YW'(by - NW'(1));
				lo_z_q  <= ZW'(bz - NW'(1));
				flags_q <= {bz != '0, by != '0, bx != '0};
			end else begin
				acc_q   <= {{16{s_tdata[15]}}, s_tdata[15:0]};
				hi_x_q  <= load_x_q;
				hi_y_q  <= load_y_q;
				hi_z_q  <= load_z_q;
				lo_x_q  <= load_x_q - XW'(1);
				lo_y_q  <= load_y_q - YW'(1);
				lo_z_q  <= load_z_q - ZW'(1);
				flags_q <= {load_z_q != '0, load_y_q != '0, load_x_q != '0};
			end
		end else if (advance) begin
			acc_q <= acc_next;
			if (cw.op != OP_READ) begin
				m_tdata_q <= acc_next;
				m_tuser_q <= kind_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= acc_next;
		end else if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	property p_accept_starts_program;
		@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && (step_q == ENTRY_LOAD || step_q == ENTRY_QUERY);
	endproperty
	assert property (p_accept_starts_program)
		else $error("accepted item did not start at a program entry");

	property p_finish_delivers;
		@(posedge clk) disable iff (!arst_n)
		advance && (cw.op != OP_READ) |=> !busy_q && m_tvalid;
	endproperty
	assert property (p_finish_delivers)
		else $error("finished item did not reach the output register");

	property p_result_follows_work;
		@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy_q);
	endproperty
	assert property (p_result_follows_work)
		else $error("result appeared without an item at work");

	property p_load_position_in_image;
		@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (NW'(load_x_q) < sx) && (NW'(load_y_q) < sy) && (NW'(load_z_q) < sz);
	endproperty
	assert property (p_load_position_in_image)
		else $error("load position left the image");

endmodule

/* verif/summed_volume_table_window_sum_checker.sv */
`timescale 1ns / 1ps
// Checker for the summed-volume table: predicts every result from the observed items and compares.
module summed_volume_table_window_sum_checker
	import svt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // pixel[15:0], end_x[22:16], end_y[29:23], end_z[34:30], zero
	input  logic        s_tuser,   // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // value[31:0]
	input  logic        m_tuser,   // result_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
	} volume_result_t;

	volume_result_t expected_sums[$];
	logic [31:0]    volume_table[DEPTH];

	int         raster_x, raster_y, raster_z;
	logic [6:0] size_x_q, size_y_q, window_x_q, window_y_q;
	logic [4:0] size_z_q, window_z_q;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] svt mismatch: %s", $time, msg);
	endtask

	task automatic restart_raster();
		raster_x = 0;
		raster_y = 0;
		raster_z = 0;
	endtask

	function automatic int extent_of(input int r, input int maxv);
		if (r == 0)
			return 1;
		return (r > maxv) ? maxv : r;
	endfunction

	function automatic int window_begin(input int e, input int s, input int w);
		if (w > e)
			return 0;
		if (e >= s)
			return (w > s) ? 0 : s - w;
		return e + 1 - w;
	endfunction

	function automatic logic [31:0] vol_at(input int x, input int y, input int z);
		return volume_table[(z * MAX_Y + y) * MAX_X + x];
	endfunction

	function automatic logic [31:0] integrate_pixel(input logic [15:0] px);
		int          x, y, z, sx, sy, sz;
		bit          hx, hy, hz;
		logic [31:0] v;
		x = raster_x;
		y = raster_y;
		z = raster_z;
		hx = (x != 0);
		hy = (y != 0);
		hz = (z != 0);
		sx = extent_of(size_x_q, MAX_X);
		sy = extent_of(size_y_q, MAX_Y);
		sz = extent_of(size_z_q, MAX_Z);
		v = {{16{px[15]}}, px};
		if (hx) v += vol_at(x - 1, y, z);
		if (hy) v += vol_at(x, y - 1, z);
		if (hz) v += vol_at(x, y, z - 1);
		if (hx && hy) v -= vol_at(x - 1, y - 1, z);
		if (hx && hz) v -= vol_at(x - 1, y, z - 1);
		if (hy && hz) v -= vol_at(x, y - 1, z - 1);
		if (hx && hy && hz) v += vol_at(x - 1, y - 1, z - 1);
		volume_table[(z * MAX_Y + y) * MAX_X + x] = v;
		if (x + 1 < sx) begin
			raster_x = x + 1;
		end else begin
			raster_x = 0;
			if (y + 1 < sy) begin
				raster_y = y + 1;
			end else begin
				raster_y = 0;
				raster_z = (z + 1 < sz) ? z + 1 : 0;
			end
		end
		return v;
	endfunction

	function automatic logic [31:0] box_sum(input logic [6:0] ex, input logic [6:0] ey,
			input logic [4:0] ez);
		int          sx, sy, sz, cx, cy, cz, bx, by, bz, px, py, pz;
		bit          hx, hy, hz;
		logic [31:0] s;
		sx = extent_of(size_x_q, MAX_X);
		sy = extent_of(size_y_q, MAX_Y);
		sz = extent_of(size_z_q, MAX_Z);
		cx = (ex >= sx) ? sx - 1 : ex;
		cy = (ey >= sy) ? sy - 1 : ey;
		cz = (ez >= sz) ? sz - 1 : ez;
		bx = window_begin(ex, sx, window_x_q);
		by = window_begin(ey, sy, window_y_q);
		bz = (sz == 1) ? 0 : window_begin(ez, sz, window_z_q);
		hx = (bx != 0);
		hy = (by != 0);
		hz = (bz != 0);
		px = hx ? bx - 1 : 0;
		py = hy ? by - 1 : 0;
		pz = hz ? bz - 1 : 0;
		s = vol_at(cx, cy, cz);
		if (hx) s -= vol_at(px, cy, cz);
		if (hy) s -= vol_at(cx, py, cz);
		if (hz) s -= vol_at(cx, cy, pz);
		if (hx && hy) s += vol_at(px, py, cz);
		if (hx && hz) s += vol_at(px, cy, pz);
		if (hy && hz) s += vol_at(cx, py, pz);
		if (hx && hy && hz) s -= vol_at(px, py, pz);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		volume_result_t want, got;
		if (!arst_n) begin
			restart_raster();
			size_x_q = 7'd64;
			size_y_q = 7'd64;
			size_z_q = 5'd1;
			window_x_q = 7'd1;
			window_y_q = 7'd1;
			window_z_q = 5'd1;
			expected_sums.delete();
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_SIZE_X: begin
						size_x_q = pwdata[6:0];
						restart_raster();
					end
					REG_SIZE_Y: begin
						size_y_q = pwdata[6:0];
						restart_raster();
					end
					REG_SIZE_Z: begin
						size_z_q = pwdata[4:0];
						restart_raster();
					end
					REG_WINDOW_X: window_x_q = pwdata[6:0];
					REG_WINDOW_Y: window_y_q = pwdata[6:0];
					REG_WINDOW_Z: window_z_q = pwdata[4:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want.kind = s_tuser;
				if (s_tuser == KIND_LOAD)
					want.value = integrate_pixel(s_tdata[15:0]);
				else
					want.value = box_sum(s_tdata[22:16], s_tdata[29:23], s_tdata[34:30]);
				expected_sums.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d value %0d",
						m_tuser, $signed(m_tdata)));
				end else begin
					got = expected_sums.pop_front();
					if (m_tuser !== got.kind)
						report_mismatch($sformatf("result kind %0b, expected %0b",
							m_tuser, got.kind));
					if (m_tdata !== got.value)
						report_mismatch($sformatf("kind %0b value %0d, expected %0d",
							got.kind, $signed(m_tdata), $signed(got.value)));
				end
			end
			pending <= expected_sums.size();
		end
	end

endmodule

/* verif/summed_volume_table_window_sum_tb.sv */
`timescale 1ns / 1ps
// Top-level testbench for the summed-volume table: clock, reset, stimulus and verdict.
module summed_volume_table_window_sum_tb;
	import svt_pkg::*;

	localparam int          LIMIT_CYCLES = 800000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          RANDOM_ITEMS = 120;
	localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // pixel[15:0], end_x[22:16], end_y[29:23], end_z[34:30], zero
	logic        s_tuser = 1'b0; // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // value[31:0]
	logic        m_tuser;        // result_kind
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int mismatches, pending, results_seen;
	int cycle_count = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int settings_run = 0;
	int cur_x = 64;
	int cur_y = 64;
	int cur_z = 1;
	bit gapless = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	summed_volume_table_window_sum u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	summed_volume_table_window_sum_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending);
			$display("summed_volume_table_window_sum regression: fail");
			$finish;
		end
	end

	function automatic int size_extent(input int r, input int maxv);
		if (r == 0)
			return 1;
		return (r > maxv) ? maxv : r;
	endfunction

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (gapless || r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int pick_end(input int extent_v, input int field_max);
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(extent_v - 1, 0);
		if (r < 80)
			return $urandom_range(field_max, 0);
		case ($urandom_range(3))
			0: return 0;
			1: return extent_v - 1;
			2: return extent_v;
			default: return field_max;
		endcase
	endfunction

	function automatic int pick_window(input int extent_v, input int field_max);
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $urandom_range(4, 0);
		if (r < 80)
			return $urandom_range(extent_v + 2, 0);
		return $urandom_range(field_max, 0);
	endfunction

	function automatic logic [39:0] pack_item(input logic [15:0] px, input logic [6:0] ex,
			input logic [6:0] ey, input logic [4:0] ez);
		return {5'd0, ez, ey, ex, px};
	endfunction

	task automatic push_item(input logic kind, input logic [39:0] data);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_load(input logic [15:0] px);
		push_item(KIND_LOAD, pack_item(px, 7'($urandom), 7'($urandom), 5'($urandom)));
		loads_sent++;
	endtask

	task automatic push_query(input int ex, input int ey, input int ez);
		push_item(KIND_QUERY, pack_item(rand_pixel(), 7'(ex), 7'(ey), 5'(ez)));
		queries_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		logic [31:0] mask;
		mask = (idx == REG_SIZE_Z || idx == REG_WINDOW_Z) ? 32'h1F : 32'h7F;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom & ~mask) | (value & mask);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic mix_items(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 65)
				push_query(pick_end(cur_x, 127), pick_end(cur_y, 127), pick_end(cur_z, 31));
			else
				push_load(rand_pixel());
		end
	endtask

	task automatic run_windows(input int wx, input int wy, input int wz, input int mixed);
		drain_results();
		write_reg(REG_WINDOW_X, wx);
		write_reg(REG_WINDOW_Y, wy);
		write_reg(REG_WINDOW_Z, wz);
		settings_run++;
		mix_items(mixed);
	endtask

	// A full image is loaded before any query so that every table entry read has been written.
	task automatic run_image(input int rx, input int ry, input int rz,
			input int wx, input int wy, input int wz, input int mixed);
		drain_results();
		write_reg(REG_SIZE_X, rx);
		write_reg(REG_SIZE_Y, ry);
		write_reg(REG_SIZE_Z, rz);
		cur_x = size_extent(rx, MAX_X);
		cur_y = size_extent(ry, MAX_Y);
		cur_z = size_extent(rz, MAX_Z);
		repeat (cur_x * cur_y * cur_z) push_load(rand_pixel());
		run_windows(wx, wy, wz, mixed);
	endtask

	initial begin : result_sink
		int stall_left, ready_left, r;
		stall_left = 0;
		ready_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done && s_tvalid) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (ready_left > 0) begin
				ready_left--;
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 4) begin
					ready_left = $urandom_range(100, 40);
					m_tready <= 1'b1;
				end else if (r < 55) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					if (r < 85)
						stall_left = $urandom_range(2, 0);
					else if (r < 97)
						stall_left = $urandom_range(14, 3);
					else
						stall_left = $urandom_range(99, 29);
				end
			end
		end
	end

	initial begin : stimulus
		int random_start, round, rx, ry, rz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Loads straight after reset run at the default extents from the origin.
		repeat (3) push_load(rand_pixel());
		drain_results();
		write_reg(REG_UNMAPPED_LO, $urandom);
		write_reg(REG_UNMAPPED_HI, $urandom);
		repeat (2) push_load(rand_pixel());

		run_image(0, 0, 0, 0, 0, 0, 4);
		run_image(5, 4, 3, 2, 3, 2, 0);
		push_query(0, 0, 0);
		push_query(127, 127, 31);
		push_query(4, 3, 2);
		push_query(5, 4, 3);
		push_query(2, 2, 1);
		push_query(1, 3, 0);
		run_windows(64, 64, 16, 0);
		push_query(127, 127, 31);
		push_query(3, 2, 2);
		run_windows(127, 127, 31, 0);
		push_query(0, 0, 0);
		push_query(4, 3, 2);
		run_windows(0, 5, 1, 0);
		push_query(3, 2, 1);
		run_image(127, 1, 1, 64, 1, 1, 10);
		run_image(1, 127, 1, 1, 64, 1, 10);
		run_image(1, 1, 31, 1, 1, 16, 10);
		run_image(2, 2, 16, 1, 1, 5, 10);

		random_start = items_sent;
		round = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			round++;
			gapless = (round == 1) || ($urandom_range(4) == 0);
			if (round == 1)
				hold_req = 1'b1;
			if ($urandom_range(99) < 85) begin
				rx = $urandom_range(7, 0);
				ry = $urandom_range(7, 0);
				rz = $urandom_range(4, 0);
			end else if ($urandom_range(1) == 0) begin
				rx = $urandom_range(127, 60);
				ry = $urandom_range(2, 0);
				rz = $urandom_range(1, 0);
			end else begin
				rx = $urandom_range(2, 0);
				ry = $urandom_range(127, 60);
				rz = $urandom_range(1, 0);
			end
			run_image(rx, ry, rz, pick_window(size_extent(rx, MAX_X), 127),
				pick_window(size_extent(ry, MAX_Y), 127),
				pick_window(size_extent(rz, MAX_Z), 31), $urandom_range(50, 20));
			if ($urandom_range(2) == 0)
				run_windows(pick_window(cur_x, 127), pick_window(cur_y, 127),
					pick_window(cur_z, 31), $urandom_range(30, 10));
		end
		gapless = 1'b0;

		drain_results();
		repeat (12) @(posedge clk);
		$display("Sent %0d load items and %0d query items across %0d register settings.",
			loads_sent, queries_sent, settings_run);
		$display("Extents ranged from one pixel to the full width, height and depth, "
			, "windows from zero to the widest value the registers hold.");
		if (mismatches == 0 && pending == 0) begin
			$display("summed_volume_table_window_sum regression: pass");
		end else begin
			$display("%0d mismatches, %0d results never seen.", mismatches, pending);
			$display("summed_volume_table_window_sum regression: fail");
		end
		$finish;
	end

endmodule

/* summed_volume_table_window_sum.f */
src/svt_pkg.sv
src/summed_volume_table_window_sum.sv
verif/summed_volume_table_window_sum_checker.sv
verif/summed_volume_table_window_sum_tb.sv
